// ===== hw/rtl/tcce_pkg.sv =====
// Shared types and constants for the text console cursor engine.
// No dependencies; used by the top level by scoped names.
package tcce_pkg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_SCROLL,
        ST_DRAIN,
        ST_EXEC,
        ST_READ,
        ST_DONE
    } state_t;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_ATTRIBUTE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_CELL     = 2'd1;

    localparam logic [7:0]  ATTR_RESET  = 8'd7;
    localparam logic [15:0] BLANK_RESET = 16'd1824;

endpackage

// ===== hw/rtl/tcce_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine: control, cursor and result channel.
// Depends on tcce_pkg and tcce_ram.
//
// The screen is ROWS x COLUMNS cells of 16 bits (attribute high, character low) held in
// one RAM with a registered read; the cursor is kept as row, column and column modulo
// TAB_STOP. Items are taken one at a time, and the next item is accepted while the
// previous result still waits on the m_ channel. A put that finds the cursor in
// scroll-pending position (row ROWS) first streams every row up one through the RAM port
// and blanks the bottom row. A clear item writes blank_cell into every cell. After reset
// the block runs a clearing pass that fills the store with the reset blank cell; no item
// is accepted until it finishes, while configuration writes are taken at any time. The
// scroll and clear passes write one cell a cycle through the single RAM write port.
module text_console_cursor_engine #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_we,
    input  logic [tcce_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_operation,
    input  logic [7:0]                         s_character,
    input  logic [4:0]                         s_read_row,
    input  logic [6:0]                         s_read_col,
    // result items
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [4:0]                         m_cursor_row,
    output logic [6:0]                         m_cursor_col,
    output logic [7:0]                         m_cell_char,
    output logic [7:0]                         m_cell_attr
);

    localparam int CELLS      = ROWS * COLUMNS;
    localparam int COPY_CELLS = COLUMNS * (ROWS - 1);
    localparam int AW         = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RW         = $clog2(ROWS + 1);
    localparam int CW         = $clog2(COLUMNS);
    localparam int MW         = $clog2(TAB_STOP);
    localparam int SW         = $clog2(COLUMNS + TAB_STOP + 1);

    // state and registers
    tcce_pkg::state_t state_reg, state_next;

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [MW-1:0] mod_reg, mod_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [7:0]    char_reg, char_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          pend_ram_reg, pend_ram_next;
    logic          rd_ok_reg, rd_ok_next;
    logic [15:0]   res_cell_reg, res_cell_next;
    logic [7:0]    attr_reg;
    logic [15:0]   blank_reg;

    logic          m_valid_reg, m_valid_next;
    logic [4:0]    m_row_reg, m_row_next;
    logic [6:0]    m_col_reg, m_col_next;
    logic [15:0]   m_cell_reg, m_cell_next;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    // put-character interpretation
    logic [7:0]    ex_ch;
    logic [RW-1:0] ex_row;
    logic [CW-1:0] ex_col;
    logic [MW-1:0] ex_mod;
    logic          ex_we;
    logic [AW-1:0] ex_addr;
    logic [SW-1:0] tab_sum;

    logic          accept;
    logic          scroll_pending;
    logic          out_free;
    logic          rd_ok;
    logic [AW-1:0] rd_addr;
    logic [RW+4:0] row_out_ext;
    logic [CW+6:0] col_out_ext;

    tcce_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign accept         = s_valid && s_ready;
    assign scroll_pending = (row_reg == RW'(ROWS));
    assign out_free       = !m_valid_reg || m_ready;

    // read item: drop the cell when row or column lies off the screen
    assign rd_ok   = (32'(s_read_row) < ROWS) && (32'(s_read_col) < COLUMNS);
    assign rd_addr = AW'(32'(s_read_row) * COLUMNS + 32'(s_read_col));

    // Interpret one put byte against the current cursor. In the idle state the byte comes
    // straight from the input; after a scroll it comes from the held copy.
    always_comb begin
        ex_ch   = (state_reg == tcce_pkg::ST_EXEC) ? char_reg : s_character;
        ex_row  = row_reg;
        ex_col  = col_reg;
        ex_mod  = mod_reg;
        ex_we   = 1'b0;
        ex_addr = AW'(32'(row_reg) * COLUMNS + 32'(col_reg));
        tab_sum = SW'(col_reg) + SW'(TAB_STOP) - SW'(mod_reg);
        case (ex_ch)
            tcce_pkg::CH_NEWLINE: begin
                ex_row = row_reg + 1'b1;
                ex_col = '0;
                ex_mod = '0;
            end
            tcce_pkg::CH_BACKSPACE: begin
                if (col_reg != '0) begin
                    ex_col = col_reg - 1'b1;
                    ex_mod = (mod_reg == '0) ? MW'(TAB_STOP - 1) : mod_reg - 1'b1;
                end
            end
            tcce_pkg::CH_TAB: begin
                // a stop at or past the row end lands on column 0 of the next row
                ex_mod = '0;
                if (tab_sum >= SW'(COLUMNS)) begin
                    ex_row = row_reg + 1'b1;
                    ex_col = '0;
                end else begin
                    ex_col = CW'(tab_sum);
                end
            end
            tcce_pkg::CH_RETURN: begin
                ex_col = '0;
                ex_mod = '0;
            end
            default: begin
                ex_we = 1'b1;
                if (col_reg == CW'(COLUMNS - 1)) begin
                    ex_row = row_reg + 1'b1;
                    ex_col = '0;
                    ex_mod = '0;
                end else begin
                    ex_col = col_reg + 1'b1;
                    ex_mod = (mod_reg == MW'(TAB_STOP - 1)) ? '0 : mod_reg + 1'b1;
                end
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tcce_pkg::ST_INIT: begin
                if (ptr_reg == AW'(CELLS - 1)) state_next = tcce_pkg::ST_IDLE;
            end
            tcce_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_operation)
                        tcce_pkg::OP_PUT: begin
                            state_next = scroll_pending ? tcce_pkg::ST_SCROLL
                                                        : tcce_pkg::ST_DONE;
                        end
                        tcce_pkg::OP_CLEAR: state_next = tcce_pkg::ST_FILL;
                        tcce_pkg::OP_READ:  state_next = tcce_pkg::ST_READ;
                        default:            state_next = tcce_pkg::ST_DONE;
                    endcase
                end
            end
            tcce_pkg::ST_FILL: begin
                if (ptr_reg == AW'(CELLS - 1)) state_next = tcce_pkg::ST_DONE;
            end
            tcce_pkg::ST_SCROLL: begin
                if (ptr_reg == AW'(CELLS - 1)) state_next = tcce_pkg::ST_DRAIN;
            end
            tcce_pkg::ST_DRAIN: state_next = tcce_pkg::ST_EXEC;
            tcce_pkg::ST_EXEC:  state_next = tcce_pkg::ST_DONE;
            tcce_pkg::ST_READ:  state_next = tcce_pkg::ST_DONE;
            tcce_pkg::ST_DONE: begin
                if (out_free) state_next = tcce_pkg::ST_IDLE;
            end
            default: state_next = tcce_pkg::ST_INIT;
        endcase
    end

    // outputs of the sequencer: handshake, RAM port and register updates
    always_comb begin
        s_ready        = (state_reg == tcce_pkg::ST_IDLE);
        row_next       = row_reg;
        col_next       = col_reg;
        mod_next       = mod_reg;
        ptr_next       = ptr_reg;
        char_next      = char_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_ram_next  = pend_ram_reg;
        rd_ok_next     = rd_ok_reg;
        res_cell_next  = res_cell_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg;
        ram_wdata      = blank_reg;
        ram_raddr      = AW'(32'(ptr_reg) + COLUMNS);

        case (state_reg)
            tcce_pkg::ST_INIT: begin
                // reset pass always uses the reset blank, whatever config says meanwhile
                ram_we    = 1'b1;
                ram_wdata = tcce_pkg::BLANK_RESET;
                ptr_next  = ptr_reg + 1'b1;
            end
            tcce_pkg::ST_IDLE: begin
                ram_raddr = rd_addr;
                if (accept) begin
                    char_next     = s_character;
                    rd_ok_next    = rd_ok;
                    res_cell_next = '0;
                    ptr_next      = '0;
                    case (s_operation)
                        tcce_pkg::OP_PUT: begin
                            if (scroll_pending) begin
                                row_next = RW'(ROWS - 1);
                            end else begin
                                row_next  = ex_row;
                                col_next  = ex_col;
                                mod_next  = ex_mod;
                                ram_we    = ex_we;
                                ram_waddr = ex_addr;
                                ram_wdata = {attr_reg, ex_ch};
                            end
                        end
                        tcce_pkg::OP_CLEAR: begin
                            row_next = '0;
                            col_next = '0;
                            mod_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tcce_pkg::ST_FILL: begin
                ram_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
            end
            tcce_pkg::ST_SCROLL: begin
                // read the cell one row down now, write it in the next cycle
                pend_next      = 1'b1;
                pend_addr_next = ptr_reg;
                pend_ram_next  = (32'(ptr_reg) < COPY_CELLS);
                ptr_next       = ptr_reg + 1'b1;
                ram_we         = pend_reg;
                ram_waddr      = pend_addr_reg;
                ram_wdata      = pend_ram_reg ? ram_rdata : blank_reg;
            end
            tcce_pkg::ST_DRAIN: begin
                ram_we    = pend_reg;
                ram_waddr = pend_addr_reg;
                ram_wdata = pend_ram_reg ? ram_rdata : blank_reg;
            end
            tcce_pkg::ST_EXEC: begin
                row_next  = ex_row;
                col_next  = ex_col;
                mod_next  = ex_mod;
                ram_we    = ex_we;
                ram_waddr = ex_addr;
                ram_wdata = {attr_reg, ex_ch};
            end
            tcce_pkg::ST_READ: begin
                res_cell_next = rd_ok_reg ? ram_rdata : '0;
            end
            default: begin
            end
        endcase
    end

    // result register: load on the done state, hold until taken
    assign row_out_ext = {5'b0, row_reg};
    assign col_out_ext = {7'b0, col_reg};

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_row_next   = m_row_reg;
        m_col_next   = m_col_reg;
        m_cell_next  = m_cell_reg;
        if (state_reg == tcce_pkg::ST_DONE && out_free) begin
            m_valid_next = 1'b1;
            m_row_next   = row_out_ext[4:0];
            m_col_next   = col_out_ext[6:0];
            m_cell_next  = res_cell_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tcce_pkg::ST_INIT;
            row_reg     <= '0;
            col_reg     <= '0;
            mod_reg     <= '0;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            attr_reg    <= tcce_pkg::ATTR_RESET;
            blank_reg   <= tcce_pkg::BLANK_RESET;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            mod_reg     <= mod_next;
            ptr_reg     <= ptr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    tcce_pkg::CFG_TEXT_ATTRIBUTE: attr_reg  <= cfg_data[7:0];
                    tcce_pkg::CFG_BLANK_CELL:     blank_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        char_reg      <= char_next;
        pend_addr_reg <= pend_addr_next;
        pend_ram_reg  <= pend_ram_next;
        rd_ok_reg     <= rd_ok_next;
        res_cell_reg  <= res_cell_next;
        m_row_reg     <= m_row_next;
        m_col_reg     <= m_col_next;
        m_cell_reg    <= m_cell_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_row = m_row_reg;
    assign m_cursor_col = m_col_reg;
    assign m_cell_char  = m_cell_reg[7:0];
    assign m_cell_attr  = m_cell_reg[15:8];

    // a put with no scroll pending moves from idle straight to the done state
    a_put_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcce_pkg::ST_IDLE && s_valid && s_operation == tcce_pkg::OP_PUT
         && row_reg != RW'(ROWS)) |=> (state_reg == tcce_pkg::ST_DONE))
        else $error("direct put did not reach the done state");

    // scroll-pending position is always column 0 at a tab phase of 0
    a_pending_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg == RW'(ROWS)) |-> (col_reg == '0 && mod_reg == '0))
        else $error("cursor past the last row with nonzero column");

    // delayed copy writes exist only inside the scroll pass
    a_pend_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == tcce_pkg::ST_SCROLL || state_reg == tcce_pkg::ST_DRAIN))
        else $error("scroll write pending outside the scroll pass");

endmodule

// ===== test/console_check_pkg.sv =====
`timescale 1ns / 1ps
// Screen and cursor predictor plus result scoreboard for the console engine bench.
// Depends on tcce_pkg for operation, control-code and register-index constants.
package console_check_pkg;

    import tcce_pkg::*;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int TAB_WIDTH   = 8;
    localparam int CELL_TOTAL  = SCREEN_COLS * SCREEN_ROWS;
    localparam int MAX_PRINTED = 60;

    // Operation code the block must treat as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Register indexes past the end of the register list; writes are dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } cursor_report_t;

    class console_scoreboard;
        int unsigned    errors;
        int unsigned    checked;
        logic [7:0]     text_attr;
        logic [15:0]    blank_value;
        int unsigned    cursor;
        logic [15:0]    cells [CELL_TOTAL];
        cursor_report_t pending_reports [$];

        function new();
            errors      = 0;
            checked     = 0;
            text_attr   = ATTR_RESET;
            blank_value = BLANK_RESET;
            cursor      = 0;
            foreach (cells[i]) cells[i] = BLANK_RESET;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_TEXT_ATTRIBUTE: text_attr = data[7:0];
                CFG_BLANK_CELL:     blank_value = data;
                default: ;
            endcase
        endfunction

        // Advance the screen by one accepted item and queue the report it causes.
        function void note_item(logic [1:0] op, logic [7:0] ch,
                                logic [4:0] rr, logic [6:0] rc);
            int unsigned    row;
            int unsigned    col;
            logic [15:0]    read_value;
            cursor_report_t rpt;
            read_value = '0;
            case (op)
                OP_PUT: begin
                    // Scroll pending: shift rows up, blank the bottom row.
                    if (cursor >= CELL_TOTAL) begin
                        for (int i = 0; i < CELL_TOTAL - SCREEN_COLS; i++)
                            cells[i] = cells[i + SCREEN_COLS];
                        for (int i = CELL_TOTAL - SCREEN_COLS; i < CELL_TOTAL; i++)
                            cells[i] = blank_value;
                        cursor = cursor - SCREEN_COLS;
                    end
                    row = cursor / SCREEN_COLS;
                    col = cursor % SCREEN_COLS;
                    case (ch)
                        CH_NEWLINE:   cursor = (row + 1) * SCREEN_COLS;
                        CH_BACKSPACE: if (col != 0) cursor = cursor - 1;
                        CH_TAB: begin
                            col = (col + TAB_WIDTH) / TAB_WIDTH * TAB_WIDTH;
                            if (col > SCREEN_COLS) col = SCREEN_COLS;
                            cursor = row * SCREEN_COLS + col;
                        end
                        CH_RETURN:    cursor = row * SCREEN_COLS;
                        default: begin
                            cells[cursor] = {text_attr, ch};
                            cursor = cursor + 1;
                        end
                    endcase
                    if (cursor > CELL_TOTAL) cursor = CELL_TOTAL;
                end
                OP_CLEAR: begin
                    foreach (cells[i]) cells[i] = blank_value;
                    cursor = 0;
                end
                OP_READ: begin
                    if (rr < SCREEN_ROWS && rc < SCREEN_COLS)
                        read_value = cells[rr * SCREEN_COLS + rc];
                end
                default: ;
            endcase
            rpt.cursor_row = 5'(cursor / SCREEN_COLS);
            rpt.cursor_col = 7'(cursor % SCREEN_COLS);
            rpt.cell_char  = read_value[7:0];
            rpt.cell_attr  = read_value[15:8];
            pending_reports.push_back(rpt);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED) $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_report(cursor_report_t got);
            cursor_report_t want;
            if (pending_reports.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", checked));
                checked++;
                return;
            end
            want = pending_reports.pop_front();
            if (got.cursor_row !== want.cursor_row)
                report($sformatf("result %0d cursor_row %0d, expected %0d",
                                 checked, got.cursor_row, want.cursor_row));
            if (got.cursor_col !== want.cursor_col)
                report($sformatf("result %0d cursor_col %0d, expected %0d",
                                 checked, got.cursor_col, want.cursor_col));
            if (got.cell_char !== want.cell_char)
                report($sformatf("result %0d cell_char 0x%02h, expected 0x%02h",
                                 checked, got.cell_char, want.cell_char));
            if (got.cell_attr !== want.cell_attr)
                report($sformatf("result %0d cell_attr 0x%02h, expected 0x%02h",
                                 checked, got.cell_attr, want.cell_attr));
            checked++;
        endtask
    endclass

endpackage

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Regression bench for text_console_cursor_engine: directed items, then paced random typing.
// Depends on tcce_pkg, console_check_pkg and the engine RTL.
module testbench;

    import console_check_pkg::*;

    localparam int    HALF_PERIOD     = 6;
    localparam int    RESET_CYCLES    = 7;
    localparam int    PHASES          = 5;
    localparam int    ITEMS_PER_PHASE = 390;
    localparam int    HOLD_AT_ITEM    = 600;
    localparam int    LONG_HOLD       = 500;
    localparam int    SETTLE_CYCLES   = 8;
    localparam int    DRAIN_CYCLES    = 40;
    // Worst case: ~2000 items each paying a full scroll pass plus gaps and stalls,
    // then taken about four times over.
    localparam longint WATCHDOG_NS    = 200_000_000;

    logic                              aclk         = 1'b0;
    logic                              aresetn      = 1'b0;
    logic                              cfg_we       = 1'b0;
    logic [tcce_pkg::CFG_INDEX_W-1:0]  cfg_index    = '0;
    logic [tcce_pkg::CFG_DATA_W-1:0]   cfg_data     = '0;
    logic                              s_valid      = 1'b0;
    logic                              s_ready;
    logic [1:0]                        s_operation  = '0;
    logic [7:0]                        s_character  = '0;
    logic [4:0]                        s_read_row   = '0;
    logic [6:0]                        s_read_col   = '0;
    logic                              m_valid;
    logic                              m_ready      = 1'b0;
    logic [4:0]                        m_cursor_row;
    logic [6:0]                        m_cursor_col;
    logic [7:0]                        m_cell_char;
    logic [7:0]                        m_cell_attr;

    console_scoreboard sb = new();

    int unsigned items_sent    = 0;
    int unsigned burst_left    = 0;
    bit          sender_gaps   = 1'b1;
    bit          hold_request  = 1'b0;
    bit          hold_served   = 1'b0;

    text_console_cursor_engine #(
        .COLUMNS  (SCREEN_COLS),
        .ROWS     (SCREEN_ROWS),
        .TAB_STOP (TAB_WIDTH)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_character  (s_character),
        .s_read_row   (s_read_row),
        .s_read_col   (s_read_col),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor_row (m_cursor_row),
        .m_cursor_col (m_cursor_col),
        .m_cell_char  (m_cell_char),
        .m_cell_attr  (m_cell_attr)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Any byte that prints, i.e. none of the four cursor-control codes.
    function automatic logic [7:0] pick_glyph();
        logic [7:0] g;
        do g = 8'($urandom);
        while (g == tcce_pkg::CH_NEWLINE || g == tcce_pkg::CH_BACKSPACE ||
               g == tcce_pkg::CH_TAB || g == tcce_pkg::CH_RETURN);
        return g;
    endfunction

    // Drop valid over the requested falling edges; one assignment per edge.
    task automatic idle(int unsigned n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Offer one item, pacing the sender in bursts, and hold it until accepted.
    task automatic push_item(logic [1:0] op, logic [7:0] ch,
                             logic [4:0] rr, logic [6:0] rc);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (sender_gaps && $urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
        end
        burst_left--;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_character <= ch;
        s_read_row  <= rr;
        s_read_col  <= rc;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(op, ch, rr, rc);
        items_sent++;
        // Ask the receiver for its long hold-off while the sender keeps going.
        if (items_sent == HOLD_AT_ITEM) hold_request = 1'b1;
    endtask

    // Stop offering and wait until every queued report has come back.
    task automatic settle();
        idle(1);
        while (sb.pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(logic [tcce_pkg::CFG_INDEX_W-1:0] index,
                                logic [tcce_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.write_register(index, data);
    endtask

    // One random stretch of console traffic. Most of it is well-formed typing
    // (text runs mostly ended by a line break, tab runs, edits) so the cursor walks
    // down to the bottom row and scrolls; the rest is reads, noise and junk.
    task automatic type_sequence();
        int unsigned kind;
        int unsigned pick;
        logic [7:0]  code;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            // Mostly short lines, now and then one that wraps past the row end.
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
                                                : $urandom_range(0, 20))
                push_item(tcce_pkg::OP_PUT, pick_glyph(), 5'($urandom), 7'($urandom));
            pick = $urandom_range(0, 19);
            if (pick < 12)
                push_item(tcce_pkg::OP_PUT, tcce_pkg::CH_NEWLINE, 5'($urandom), 7'($urandom));
            else if (pick < 14)
                push_item(tcce_pkg::OP_PUT, tcce_pkg::CH_RETURN, 5'($urandom), 7'($urandom));
            else if (pick < 17)
                push_item(tcce_pkg::OP_PUT, tcce_pkg::CH_TAB, 5'($urandom), 7'($urandom));
        end else if (kind < 60) begin
            repeat ($urandom_range(1, 11))
                push_item(tcce_pkg::OP_PUT, tcce_pkg::CH_TAB, 5'($urandom), 7'($urandom));
        end else if (kind < 70) begin
            repeat ($urandom_range(1, 6))
                push_item(tcce_pkg::OP_PUT, tcce_pkg::CH_BACKSPACE, 5'($urandom), 7'($urandom));
            if ($urandom_range(0, 2) == 0)
                push_item(tcce_pkg::OP_PUT, tcce_pkg::CH_RETURN, 5'($urandom), 7'($urandom));
        end else if (kind < 85) begin
            // Reads lean on the bottom rows, where scrolls move content.
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 7) == 0)
                    push_item(tcce_pkg::OP_READ, 8'($urandom), 5'($urandom), 7'($urandom));
                else
                    push_item(tcce_pkg::OP_READ, 8'($urandom),
                              5'($urandom_range(0, 1) ? $urandom_range(20, 24)
                                                      : $urandom_range(0, 24)),
                              7'($urandom_range(0, SCREEN_COLS - 1)));
            end
        end else if (kind < 95) begin
            repeat ($urandom_range(1, 3)) begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    push_item(tcce_pkg::OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
                else if (pick < 6)
                    push_item(OP_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
                else if (pick < 11)
                    push_item(tcce_pkg::OP_READ, 8'($urandom), 5'($urandom), 7'($urandom));
                else
                    push_item(tcce_pkg::OP_PUT, 8'($urandom), 5'($urandom), 7'($urandom));
            end
        end else begin
            // Broken typing: control codes jumbled with stray bytes.
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 4))
                    0:       code = tcce_pkg::CH_NEWLINE;
                    1:       code = tcce_pkg::CH_BACKSPACE;
                    2:       code = tcce_pkg::CH_TAB;
                    3:       code = tcce_pkg::CH_RETURN;
                    default: code = pick_glyph();
                endcase
                push_item(tcce_pkg::OP_PUT, code, 5'($urandom), 7'($urandom));
            end
        end
    endtask

    // Compare every accepted result against the oldest queued report.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_report({m_cursor_row, m_cursor_col, m_cell_char, m_cell_attr});
    end

    // Receiver: stall on a rolling 16-bit mask that is redrawn for each window;
    // a third of the windows stall never. Once the sender asks, hold off for a
    // long stretch so the engine backs up and drops s_ready.
    initial begin : receiver
        logic [15:0] stall_mask;
        int unsigned slot;
        stall_mask = '1;
        slot       = 0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end else begin
                if (slot % 64 == 0)
                    stall_mask = ($urandom_range(0, 2) == 0) ? '1 : 16'($urandom);
                m_ready <= stall_mask[slot % 16];
                slot++;
            end
        end
    end

    initial begin : stimulus
        int unsigned phase_start;
        bit          paused;
        paused = 1'b0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset registers, read extremes and out-of-range cells, the
        // unused opcode, extreme bytes, backspace at column zero and a tab run
        // that wraps off the row end, then a clear.
        push_item(tcce_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
        push_item(tcce_pkg::OP_READ, 8'hFF, 5'd24, 7'd79);
        push_item(tcce_pkg::OP_READ, 8'h00, 5'd25, 7'd0);
        push_item(tcce_pkg::OP_READ, 8'hFF, 5'd31, 7'd127);
        push_item(OP_UNUSED, 8'h5A, 5'd31, 7'd127);
        push_item(tcce_pkg::OP_PUT, 8'h41, 5'd0, 7'd0);
        push_item(tcce_pkg::OP_PUT, 8'hFF, 5'd31, 7'd127);
        push_item(tcce_pkg::OP_PUT, 8'h00, 5'd0, 7'd0);
        push_item(tcce_pkg::OP_PUT, tcce_pkg::CH_BACKSPACE, 5'd0, 7'd0);
        push_item(tcce_pkg::OP_PUT, tcce_pkg::CH_RETURN, 5'd0, 7'd0);
        push_item(tcce_pkg::OP_PUT, tcce_pkg::CH_BACKSPACE, 5'd0, 7'd0);
        repeat (SCREEN_COLS / TAB_WIDTH)
            push_item(tcce_pkg::OP_PUT, tcce_pkg::CH_TAB, 5'($urandom), 7'($urandom));
        push_item(tcce_pkg::OP_READ, 8'h00, 5'd0, 7'd1);
        push_item(tcce_pkg::OP_CLEAR, 8'hFF, 5'd31, 7'd127);

        // Random phases, each under its own register setting, written idle.
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: begin
                    write_config(tcce_pkg::CFG_TEXT_ATTRIBUTE, 16'h0000);
                    write_config(tcce_pkg::CFG_BLANK_CELL, 16'h0000);
                end
                1: begin
                    write_config(tcce_pkg::CFG_TEXT_ATTRIBUTE, 16'h00FF);
                    write_config(tcce_pkg::CFG_BLANK_CELL, 16'hFFFF);
                end
                2: begin
                    write_config(tcce_pkg::CFG_TEXT_ATTRIBUTE, 16'($urandom));
                    write_config(tcce_pkg::CFG_BLANK_CELL, 16'($urandom));
                    write_config(CFG_SPARE_LO, 16'($urandom));
                    write_config(CFG_SPARE_HI, 16'($urandom));
                end
                3: begin
                    write_config(tcce_pkg::CFG_TEXT_ATTRIBUTE, 16'h001F);
                    write_config(tcce_pkg::CFG_BLANK_CELL, 16'($urandom));
                end
                default: begin
                    write_config(tcce_pkg::CFG_BLANK_CELL, 16'($urandom));
                    write_config(tcce_pkg::CFG_TEXT_ATTRIBUTE, 16'($urandom));
                end
            endcase
            // Run one phase back to back on the sender side.
            sender_gaps = (phase != 3);
            if (phase % 2 == 1)
                push_item(tcce_pkg::OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                type_sequence();
                // Pause once mid-phase until the engine has answered everything.
                if (phase == 2 && !paused &&
                    items_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("text_console_cursor_engine regression: pass");
        else
            $display("text_console_cursor_engine regression: fail");
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("text_console_cursor_engine regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_ram.sv
hw/rtl/text_console_cursor_engine.sv
test/console_check_pkg.sv
test/testbench.sv
